/* design/dcm_to_quaternion_defines.svh */
// Assertion macros for the DCM to quaternion block.
`ifndef DCM_TO_QUATERNION_DEFINES_SVH
`define DCM_TO_QUATERNION_DEFINES_SVH
`ifndef ASSERT_OFF
// clocked assertion, masked during reset
`define DCMQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// clocked assertion, checked during reset too
`define DCMQ_ASSERT_RST(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DCMQ_ASSERT(lbl, clk, rstn, prop, msg)
`define DCMQ_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

/* design/dcmq_pkg.sv */
// Shared constants and types of the DCM to quaternion block.
package dcmq_pkg;
  localparam int FRAC_BITS = 14;
  localparam int W   = 16;                  // element and part width
  localparam int VW  = W + 1;               // clamped radicand width
  localparam int NW  = VW + FRAC_BITS;      // radicand scaled by 2^F
  localparam int RW  = (NW + 1) / 2;        // root width, one bit per sqrt stage
  localparam int SQW = 2 * RW;              // sqrt input, padded to pairs
  localparam int DW  = W + 2;               // signed numerator width
  localparam int MW  = W + 1;               // numerator magnitude width
  localparam int BW  = RW + 1;              // divisor width (2r)
  localparam int AW  = MW + FRAC_BITS;      // dividend width
  localparam int QW  = W;                   // quotient bits, one per div stage
  localparam int CW  = (AW > RW + QW + 1) ? AW : RW + QW + 1;
  localparam int PW  = 2;

  localparam logic [PW-1:0] PIV_X = 2'd0;
  localparam logic [PW-1:0] PIV_Y = 2'd1;
  localparam logic [PW-1:0] PIV_Z = 2'd2;
  localparam logic [PW-1:0] PIV_W = 2'd3;   // positive trace, scalar pivot

  localparam logic [QW-1:0] POS_MAX = QW'((1 << (W - 1)) - 1);
  localparam logic [QW-1:0] NEG_MAX = QW'(1 << (W - 1));

  typedef logic signed [W-1:0]  elem_t;
  typedef logic signed [DW-1:0] num_t;
  typedef logic [RW-1:0]        root_t;

  // rides along the square root pipeline
  typedef struct packed {
    logic [PW-1:0] piv;
    num_t          d0;
    num_t          d1;
    num_t          d2;
  } dcmq_side_t;

  // rides along the divider pipeline
  typedef struct packed {
    logic [PW-1:0] piv;
    logic          deg;
    elem_t         pv;
  } dcmq_tag_t;
endpackage

/* design/dcmq_if.sv */
// Valid/ready channels of the DCM to quaternion block.
interface dcmq_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
  modport source(output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                 input ready);
  modport sink(input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
               output ready);
endinterface

interface dcmq_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] q_scalar, q_x, q_y, q_z;
  logic degenerate;
  modport source(output valid, q_scalar, q_x, q_y, q_z, degenerate, input ready);
  modport sink(input valid, q_scalar, q_x, q_y, q_z, degenerate, output ready);
endinterface

/* design/dcm_to_quaternion.sv */
// Top level: DCM to quaternion conversion by Shepperd's method.
//
// Input channel in_ch carries the nine Q2.14 matrix elements; output
// channel out_ch carries the scalar-first quaternion in Q2.14 plus a
// degenerate flag (pivot root zero, all parts zero). Both are valid/ready;
// a transaction completes when valid and ready are high at a clock edge.
//
// Pipeline: 34 register stages, one stage for trace, pivot choice and
// numerators, 16 square root stages (one root bit each), 16 divider
// stages (one quotient bit each, three lanes), and the output register.
// Throughput: one matrix per cycle; every stage takes a new transaction
// each cycle the pipeline advances.
//
// The whole pipeline advances whenever the output register is empty or
// being read. When the receiver stalls with a result waiting, in_ch.ready
// drops and every stage holds; nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all stage valid bits.
module dcm_to_quaternion (
  input  logic       clk,
  input  logic       rst_n,
  dcmq_in_if.sink    in_ch,
  dcmq_out_if.source out_ch
);
  `include "dcm_to_quaternion_defines.svh"
  import dcmq_pkg::*;

  logic en;

  // front stage: trace, pivot, radicand and numerators
  logic signed [W+2:0] trace;
  logic signed [W+3:0] v_raw;
  logic [VW-1:0]       v_clamp;
  dcmq_side_t          side_nxt;

  logic                f_valid_r;
  logic [VW-1:0]       f_v_r;
  dcmq_side_t          f_side_r;

  // square root outputs
  logic                s_valid;
  root_t               s_root;
  dcmq_side_t          s_side;
  num_t                s_d [3];
  dcmq_tag_t           s_tag;

  // divider outputs
  logic                d_valid;
  elem_t               d_q [3];
  dcmq_tag_t           d_tag;

  // output register
  logic                out_valid_r;
  elem_t               q_s_r, q_x_r, q_y_r, q_z_r;
  logic                deg_r;
  elem_t               q_s_nxt, q_x_nxt, q_y_nxt, q_z_nxt;

  assign en          = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en;

  always_comb begin
    logic signed [W+1:0] e00, e11, e22;
    e00   = (W+2)'(in_ch.m00);
    e11   = (W+2)'(in_ch.m11);
    e22   = (W+2)'(in_ch.m22);
    trace = (W+3)'(e00) + (W+3)'(e11) + (W+3)'(e22);
    if (trace > 0) begin
      side_nxt.piv = PIV_W;
      v_raw        = (W+4)'(trace) + (W+4)'(1 << FRAC_BITS);
      side_nxt.d0  = DW'(in_ch.m12) - DW'(in_ch.m21);
      side_nxt.d1  = DW'(in_ch.m20) - DW'(in_ch.m02);
      side_nxt.d2  = DW'(in_ch.m01) - DW'(in_ch.m10);
    end else if (in_ch.m22 > in_ch.m00 && in_ch.m22 > in_ch.m11) begin
      // z pivot: strictly above the current largest
      side_nxt.piv = PIV_Z;
      v_raw        = (W+4)'(e22) - ((W+4)'(e11) + (W+4)'(e00))
                     + (W+4)'(1 << FRAC_BITS);
      side_nxt.d0  = DW'(in_ch.m01) - DW'(in_ch.m10);
      side_nxt.d1  = DW'(in_ch.m20) + DW'(in_ch.m02);
      side_nxt.d2  = DW'(in_ch.m12) + DW'(in_ch.m21);
    end else if (in_ch.m11 > in_ch.m00) begin
      side_nxt.piv = PIV_Y;
      v_raw        = (W+4)'(e11) - ((W+4)'(e22) + (W+4)'(e00))
                     + (W+4)'(1 << FRAC_BITS);
      side_nxt.d0  = DW'(in_ch.m20) - DW'(in_ch.m02);
      side_nxt.d1  = DW'(in_ch.m10) + DW'(in_ch.m01);
      side_nxt.d2  = DW'(in_ch.m12) + DW'(in_ch.m21);
    end else begin
      side_nxt.piv = PIV_X;
      v_raw        = (W+4)'(e00) - ((W+4)'(e11) + (W+4)'(e22))
                     + (W+4)'(1 << FRAC_BITS);
      side_nxt.d0  = DW'(in_ch.m12) - DW'(in_ch.m21);
      side_nxt.d1  = DW'(in_ch.m10) + DW'(in_ch.m01);
      side_nxt.d2  = DW'(in_ch.m20) + DW'(in_ch.m02);
    end
    // clamp keeps a negative radicand out of the square root
    v_clamp = (v_raw < 0) ? '0 : VW'(v_raw);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (en) begin
      f_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_v_r    <= v_clamp;
      f_side_r <= side_nxt;
    end
  end

  dcmq_sqrt u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (f_valid_r),
    .in_n      (SQW'({f_v_r, {FRAC_BITS{1'b0}}})),
    .in_side   (f_side_r),
    .out_valid (s_valid),
    .out_root  (s_root),
    .out_side  (s_side)
  );

  assign s_d[0]    = s_side.d0;
  assign s_d[1]    = s_side.d1;
  assign s_d[2]    = s_side.d2;
  assign s_tag.piv = s_side.piv;
  assign s_tag.deg = (s_root == '0);
  assign s_tag.pv  = elem_t'(s_root >> 1);

  dcmq_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s_valid),
    .in_root   (s_root),
    .in_d      (s_d),
    .in_tag    (s_tag),
    .out_valid (d_valid),
    .out_q     (d_q),
    .out_tag   (d_tag)
  );

  // place pivot part, zero everything on a degenerate root
  always_comb begin
    q_s_nxt = d_q[0];
    q_x_nxt = d_q[1];
    q_y_nxt = d_q[2];
    q_z_nxt = d_tag.pv;
    unique case (d_tag.piv)
      PIV_W: begin
        q_s_nxt = d_tag.pv; q_x_nxt = d_q[0]; q_y_nxt = d_q[1]; q_z_nxt = d_q[2];
      end
      PIV_X: begin
        q_s_nxt = d_q[0]; q_x_nxt = d_tag.pv; q_y_nxt = d_q[1]; q_z_nxt = d_q[2];
      end
      PIV_Y: begin
        q_s_nxt = d_q[0]; q_x_nxt = d_q[1]; q_y_nxt = d_tag.pv; q_z_nxt = d_q[2];
      end
      default: begin
        q_s_nxt = d_q[0]; q_x_nxt = d_q[1]; q_y_nxt = d_q[2]; q_z_nxt = d_tag.pv;
      end
    endcase
    if (d_tag.deg) begin
      q_s_nxt = '0; q_x_nxt = '0; q_y_nxt = '0; q_z_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_s_r <= q_s_nxt;
      q_x_r <= q_x_nxt;
      q_y_r <= q_y_nxt;
      q_z_r <= q_z_nxt;
      deg_r <= d_tag.deg;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.q_scalar   = q_s_r;
  assign out_ch.q_x        = q_x_r;
  assign out_ch.q_y        = q_y_r;
  assign out_ch.q_z        = q_z_r;
  assign out_ch.degenerate = deg_r;

  `DCMQ_ASSERT(a_deg_zero, clk, rst_n, (out_valid_r && deg_r) |-> (q_s_r == '0 && q_x_r == '0 && q_y_r == '0 && q_z_r == '0), "degenerate result with nonzero part")
  `DCMQ_ASSERT(a_stall_holds_input, clk, rst_n, (out_valid_r && !out_ch.ready) |-> !in_ch.ready, "input taken while output stalled")
  `DCMQ_ASSERT_RST(a_reset_clears, clk, !rst_n |=> !out_valid_r, "output valid after reset")
endmodule

/* design/dcmq_sqrt.sv */
// Pipelined integer square root, one root bit per stage.
module dcmq_sqrt (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [dcmq_pkg::SQW-1:0] in_n,
  input  dcmq_pkg::dcmq_side_t  in_side,
  output logic                  out_valid,
  output dcmq_pkg::root_t       out_root,
  output dcmq_pkg::dcmq_side_t  out_side
);
  import dcmq_pkg::*;

  logic             stg_valid [0:RW];
  logic [RW:0]      stg_rem   [0:RW];
  logic [RW-1:0]    stg_root  [0:RW];
  logic [SQW-1:0]   stg_n     [0:RW];
  dcmq_side_t       stg_side  [0:RW];

  assign stg_valid[0] = in_valid;
  assign stg_rem[0]   = '0;
  assign stg_root[0]  = '0;
  assign stg_n[0]     = in_n;
  assign stg_side[0]  = in_side;

  for (genvar s = 0; s < RW; s++) begin : g_stage
    logic [RW+2:0] t;
    logic [RW+2:0] trial;
    logic          ge;
    logic [RW:0]   rem_nxt;
    logic [RW-1:0] root_nxt;

    always_comb begin
      t        = {stg_rem[s], stg_n[s][SQW-1 -: 2]};
      trial    = {1'b0, stg_root[s], 2'b01};
      ge       = (t >= trial);
      rem_nxt  = ge ? (RW+1)'(t - trial) : t[RW:0];
      root_nxt = {stg_root[s][RW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_valid[s+1] <= 1'b0;
      end else if (en) begin
        stg_valid[s+1] <= stg_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_rem[s+1]  <= rem_nxt;
        stg_root[s+1] <= root_nxt;
        stg_n[s+1]    <= {stg_n[s][SQW-3:0], 2'b00};
        stg_side[s+1] <= stg_side[s];
      end
    end
  end

  assign out_valid = stg_valid[RW];
  assign out_root  = stg_root[RW];
  assign out_side  = stg_side[RW];
endmodule

/* design/dcmq_div.sv */
// Three-lane pipelined restoring divider, one quotient bit per stage, saturated.
module dcmq_div (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_valid,
  input  dcmq_pkg::root_t      in_root,
  input  dcmq_pkg::num_t       in_d [3],
  input  dcmq_pkg::dcmq_tag_t  in_tag,
  output logic                 out_valid,
  output dcmq_pkg::elem_t      out_q [3],
  output dcmq_pkg::dcmq_tag_t  out_tag
);
  import dcmq_pkg::*;

  logic          stg_valid [0:QW];
  logic [BW-1:0] stg_b     [0:QW];
  dcmq_tag_t     stg_tag   [0:QW];
  logic [BW-1:0] stg_rem   [0:QW][3];
  logic [QW-1:0] stg_q     [0:QW][3];
  logic [QW-1:0] stg_abits [0:QW][3];
  logic          stg_neg   [0:QW][3];
  logic          stg_ovf   [0:QW][3];

  assign stg_valid[0] = in_valid;
  assign stg_b[0]     = {in_root, 1'b0};
  assign stg_tag[0]   = in_tag;

  for (genvar l = 0; l < 3; l++) begin : g_lane
    logic [MW-1:0] mag;
    logic [CW-1:0] a_w;
    logic [CW-1:0] lim_w;
    always_comb begin
      mag   = in_d[l][DW-1] ? MW'(-in_d[l]) : MW'(in_d[l]);
      a_w   = CW'(mag) << FRAC_BITS;
      lim_w = CW'(in_root) << (QW + 1);
    end
    assign stg_neg[0][l]   = in_d[l][DW-1];
    assign stg_ovf[0][l]   = (a_w >= lim_w);
    assign stg_rem[0][l]   = BW'(a_w >> QW);
    assign stg_abits[0][l] = a_w[QW-1:0];
    assign stg_q[0][l]     = '0;
  end

  for (genvar s = 0; s < QW; s++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stg_valid[s+1] <= 1'b0;
      end else if (en) begin
        stg_valid[s+1] <= stg_valid[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        stg_b[s+1]   <= stg_b[s];
        stg_tag[s+1] <= stg_tag[s];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [BW:0] t;
      logic        ge;
      always_comb begin
        t  = {stg_rem[s][l], stg_abits[s][l][QW-1]};
        ge = (t >= {1'b0, stg_b[s]});
      end
      always_ff @(posedge clk) begin
        if (en) begin
          stg_rem[s+1][l]   <= ge ? BW'(t - {1'b0, stg_b[s]}) : t[BW-1:0];
          stg_q[s+1][l]     <= {stg_q[s][l][QW-2:0], ge};
          stg_abits[s+1][l] <= {stg_abits[s][l][QW-2:0], 1'b0};
          stg_neg[s+1][l]   <= stg_neg[s][l];
          stg_ovf[s+1][l]   <= stg_ovf[s][l];
        end
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_sat
    always_comb begin
      if (stg_neg[QW][l]) begin
        if (stg_ovf[QW][l] || stg_q[QW][l] > NEG_MAX) out_q[l] = elem_t'(NEG_MAX);
        else                                          out_q[l] = elem_t'(-stg_q[QW][l]);
      end else begin
        if (stg_ovf[QW][l] || stg_q[QW][l] > POS_MAX) out_q[l] = elem_t'(POS_MAX);
        else                                          out_q[l] = elem_t'(stg_q[QW][l]);
      end
    end
  end

  assign out_valid = stg_valid[QW];
  assign out_tag   = stg_tag[QW];
endmodule

/* tb/tb_dcmq_pkg.sv */
// Testbench-side types for the DCM to quaternion block.
`timescale 1ns / 100ps
package tb_dcmq_pkg;
  import dcmq_pkg::*;

  typedef struct {
    elem_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
  } dcm_t;

  typedef struct {
    elem_t q_scalar, q_x, q_y, q_z;
    logic  degenerate;
  } quat_t;
endpackage

/* tb/tb.sv */
// Testbench top: random and directed matrices against a quaternion predictor.
`timescale 1ns / 100ps
module tb;
  import dcmq_pkg::*;
  import tb_dcmq_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #1 clk = ~clk;

  dcmq_in_if  in_ch();
  dcmq_out_if out_ch();

  dcm_to_quaternion dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  quat_t quat_q[$];   // predicted quaternions, oldest first
  int    n_fail = 0;
  int    idle_pct = 34;   // both sides; zero during the no-idle stretch
  int    hold_cycles = 0; // receiver hold-off, counted down by the sink

  // Integer square root, floor, of a 64-bit value.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  // d * 2^F / (2r), truncated toward zero, saturated to 16 bits
  function automatic elem_t div_part(longint d, longint unsigned r);
    longint unsigned mag, qt;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    qt = (mag << FRAC_BITS) / (r << 1);
    if (d < 0) begin
      if (qt > 32768) qt = 32768;
      return elem_t'(-longint'(qt));
    end
    if (qt > 32767) qt = 32767;
    return elem_t'(qt);
  endfunction

  // Shepperd conversion, bit exact to the block.
  function automatic quat_t shepperd(dcm_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22, tr, v, one, d0, d1, d2;
    longint unsigned r;
    logic [PW-1:0] piv;
    elem_t pv, pa, pb, pc;
    quat_t q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    one = longint'(1) << FRAC_BITS;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      piv = PIV_W;
      v = tr + one;
      d0 = a12 - a21; d1 = a20 - a02; d2 = a01 - a10;
    end else begin
      // largest diagonal; ties keep the lower index
      piv = PIV_X;
      if (a11 > a00) piv = PIV_Y;
      if (a22 > ((piv == PIV_Y) ? a11 : a00)) piv = PIV_Z;
      if (piv == PIV_X) begin
        v = a00 - (a11 + a22) + one;
        d0 = a12 - a21; d1 = a10 + a01; d2 = a20 + a02;
      end else if (piv == PIV_Y) begin
        v = a11 - (a22 + a00) + one;
        d0 = a20 - a02; d1 = a10 + a01; d2 = a12 + a21;
      end else begin
        v = a22 - (a11 + a00) + one;
        d0 = a01 - a10; d1 = a20 + a02; d2 = a12 + a21;
      end
    end
    if (v < 0) v = 0;  // clamp, as the block does
    r = int_sqrt(longint'(v) << FRAC_BITS);
    q = '{default: '0};
    if (r == 0) begin
      q.degenerate = 1'b1;
      return q;
    end
    pv = ((r >> 1) > 32767) ? elem_t'(32767) : elem_t'(r >> 1);
    pa = div_part(d0, r);
    pb = div_part(d1, r);
    pc = div_part(d2, r);
    case (piv)
      PIV_W: begin q.q_scalar = pv; q.q_x = pa; q.q_y = pb; q.q_z = pc; end
      PIV_X: begin q.q_scalar = pa; q.q_x = pv; q.q_y = pb; q.q_z = pc; end
      PIV_Y: begin q.q_scalar = pa; q.q_x = pb; q.q_y = pv; q.q_z = pc; end
      default: begin q.q_scalar = pa; q.q_x = pb; q.q_y = pc; q.q_z = pv; end
    endcase
    return q;
  endfunction

  // Offer one matrix, with a random gap first; returns after the transaction.
  // Valid stays high afterwards; the next gap or the end of the run drops it.
  task automatic send_matrix(dcm_t m);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (idle_pct != 0 && $urandom_range(99) < idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.m00 <= m.m00; in_ch.m01 <= m.m01; in_ch.m02 <= m.m02;
    in_ch.m10 <= m.m10; in_ch.m11 <= m.m11; in_ch.m12 <= m.m12;
    in_ch.m20 <= m.m20; in_ch.m21 <= m.m21; in_ch.m22 <= m.m22;
    do @(posedge clk); while (!in_ch.ready);
    quat_q.push_back(shepperd(m));
  endtask

  function automatic elem_t rnd_elem();
    return elem_t'($urandom);
  endfunction

  function automatic dcm_t rnd_dcm();
    dcm_t m;
    m = '{rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem(),
          rnd_elem(), rnd_elem(), rnd_elem(), rnd_elem()};
    return m;
  endfunction

  // Near-rotation: cosine-like entries in [-1, 1], off diagonals alike.
  function automatic elem_t rnd_unit();
    return elem_t'($urandom_range(32768) - 16384);
  endfunction

  function automatic dcm_t rnd_rot_like();
    dcm_t m;
    m = '{rnd_unit(), rnd_unit(), rnd_unit(), rnd_unit(), rnd_unit(),
          rnd_unit(), rnd_unit(), rnd_unit(), rnd_unit()};
    return m;
  endfunction

  function automatic dcm_t diag(elem_t a, elem_t b, elem_t c, elem_t off);
    dcm_t m;
    m = '{a, off, off, off, b, off, off, off, c};
    return m;
  endfunction

  // Sink: random ready, plus a long hold-off when asked.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
      out_ch.ready <= (hold_cycles <= 1) &&
                      !(idle_pct != 0 && $urandom_range(99) < idle_pct);
    end
  end

  // Check each output transaction against the oldest prediction.
  always @(posedge clk) begin
    quat_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (quat_q.size() == 0) begin
        $error("unexpected output transaction");
        n_fail++;
      end else begin
        want = quat_q.pop_front();
        if (out_ch.q_scalar !== want.q_scalar) begin
          $error("q_scalar: expected %0d, got %0d", want.q_scalar, out_ch.q_scalar);
          n_fail++;
        end
        if (out_ch.q_x !== want.q_x) begin
          $error("q_x: expected %0d, got %0d", want.q_x, out_ch.q_x);
          n_fail++;
        end
        if (out_ch.q_y !== want.q_y) begin
          $error("q_y: expected %0d, got %0d", want.q_y, out_ch.q_y);
          n_fail++;
        end
        if (out_ch.q_z !== want.q_z) begin
          $error("q_z: expected %0d, got %0d", want.q_z, out_ch.q_z);
          n_fail++;
        end
        if (out_ch.degenerate !== want.degenerate) begin
          $error("degenerate: expected %0b, got %0b", want.degenerate,
                 out_ch.degenerate);
          n_fail++;
        end
      end
    end
  end

  // Corners: identity, half-turns about each axis, field extremes and ties.
  task automatic test_directed();
    dcm_t m;
    send_matrix(diag(16384, 16384, 16384, 0));        // identity, trace branch
    send_matrix(diag(16384, -16384, -16384, 0));      // x pivot
    send_matrix(diag(-16384, 16384, -16384, 0));      // y pivot
    send_matrix(diag(-16384, -16384, 16384, 0));      // z pivot
    send_matrix(diag(-16384, -16384, -16384, 0));     // tie, keeps x
    send_matrix(diag(-8192, -4096, -4096, 0));        // y,z tie, keeps y
    send_matrix(diag(-32768, -32768, -32768, 0));     // all at minimum, tie keeps x
    send_matrix(diag(-16384, -16384, -16384, 16384)); // tie, keeps x, off diagonals set
    send_matrix(diag(0, 0, 0, 0));                    // trace zero
    send_matrix(diag(-8192, -8192, 0, 0));            // z pivot via zero
    send_matrix(diag(1, 0, 0, 0));                    // smallest positive trace
    send_matrix(diag(32767, 32767, 32767, 32767));    // all max
    send_matrix(diag(32767, 32767, 32767, -32768));   // max diag, min off
    send_matrix(diag(-32768, -32768, -32768, 32767));
    m = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
    send_matrix(m);
    m = '{0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0};
    send_matrix(m);
    m = '{-16384, -1, -1, -1, -16384, -1, -1, -1, -16384};
    send_matrix(m);
    m = '{-1, 0, 0, 0, -1, 0, 0, 0, -1};
    send_matrix(m);
  endtask

  task automatic test_random(int count);
    repeat (count) begin
      case ($urandom_range(3))
        0: send_matrix(rnd_dcm());
        default: send_matrix(rnd_rot_like());
      endcase
    end
  endtask

  // Full rate on both sides, no gaps at all.
  task automatic test_no_idle(int count);
    idle_pct = 0;
    test_random(count);
    idle_pct = 34;
  endtask

  // Receiver holds off while the sender keeps offering, filling the pipeline.
  task automatic test_backpressure(int count);
    hold_cycles = 150;
    test_random(count);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    {in_ch.m00, in_ch.m01, in_ch.m02, in_ch.m10, in_ch.m11, in_ch.m12,
     in_ch.m20, in_ch.m21, in_ch.m22} = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(800);
    test_no_idle(400);
    test_backpressure(200);
    test_random(230);
    in_ch.valid <= 1'b0;
    while (quat_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_fail == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #200000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

/* dcm_to_quaternion.f */
+incdir+design
design/dcmq_pkg.sv
design/dcmq_if.sv
design/dcmq_sqrt.sv
design/dcmq_div.sv
design/dcm_to_quaternion.sv
tb/tb_dcmq_pkg.sv
tb/tb.sv
